>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro takes a label, the property terms and a message; clock is clk, reset arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/dtp_pkg.sv
// Types, constants and field tables for the date-time string parser.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package dtp_pkg;

	localparam logic [3:0] TERM_POS = 4'd14;
	localparam logic [3:0] IDLE_POS = 4'd15;

	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_WILD = 8'h3F;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_TERM  = 2'd1,
		ST_FIELD_ERR = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		F_YEAR   = 3'd0,
		F_MONTH  = 3'd1,
		F_DAY    = 3'd2,
		F_HOUR   = 3'd3,
		F_MINUTE = 3'd4,
		F_SECOND = 3'd5
	} field_t;

	// Field that owns a character position (0..13).
	function automatic field_t field_of(input logic [3:0] pos);
		field_t f;
		unique case (pos)
			4'd0, 4'd1, 4'd2, 4'd3: f = F_YEAR;
			4'd4, 4'd5:             f = F_MONTH;
			4'd6, 4'd7:             f = F_DAY;
			4'd8, 4'd9:             f = F_HOUR;
			4'd10, 4'd11:           f = F_MINUTE;
			default:                f = F_SECOND;
		endcase
		return f;
	endfunction

	function automatic logic is_first(input logic [3:0] pos);
		return (pos == 4'd0) || (pos == 4'd4) || (pos == 4'd6) ||
			(pos == 4'd8) || (pos == 4'd10) || (pos == 4'd12);
	endfunction

	function automatic logic is_last(input logic [3:0] pos);
		return (pos == 4'd3) || (pos == 4'd5) || (pos == 4'd7) ||
			(pos == 4'd9) || (pos == 4'd11) || (pos == 4'd13);
	endfunction

	function automatic logic [13:0] field_hi(input field_t f);
		logic [13:0] hi;
		unique case (f)
			F_YEAR:   hi = 14'd9999;
			F_MONTH:  hi = 14'd12;
			F_DAY:    hi = 14'd30;
			F_HOUR:   hi = 14'd24;
			default:  hi = 14'd60;
		endcase
		return hi;
	endfunction

	function automatic logic [13:0] field_lo(input field_t f);
		logic [13:0] lo;
		unique case (f)
			F_YEAR, F_MONTH, F_DAY: lo = 14'd1;
			default:                lo = 14'd0;
		endcase
		return lo;
	endfunction

endpackage

>>> sv/datetime_string_parser.sv
// Date-time string parser: one character per word, one result on the terminator.
// Path: a character is captured in the input register, then updates the parse state and,
// for the terminator, loads the result register once that register is free.
// Throughput: one character per cycle when not stalled; result and input stages run concurrently.
// Reset (arst_n low) empties both stages and leaves the parser idle until a start character.
// Depends on dtp_pkg.
`timescale 1ns / 1ps

module datetime_string_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        start_flag,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [13:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [5:0]  wildcard_flags
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       start_s1;

	// parse state
	logic [3:0]  pos_q;
	logic [13:0] acc_q;
	logic [13:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [5:0]  wild_q;
	logic        err_q;

	// result register
	logic        res_valid_q;
	logic [1:0]  status_q;
	logic [13:0] year_res_q;
	logic [3:0]  month_res_q;
	logic [4:0]  day_res_q;
	logic [4:0]  hour_res_q;
	logic [5:0]  minute_res_q;
	logic [5:0]  second_res_q;
	logic [5:0]  wild_res_q;

	logic        slot_free;
	logic        is_term;
	logic        proc;
	logic [3:0]  pos_e;
	logic [13:0] acc_e;
	logic [5:0]  wild_e;
	logic        err_e;
	dtp_pkg::field_t fld;
	logic        first_c;
	logic        last_c;
	logic [5:0]  wild_n;
	logic        wild_bit;
	logic        is_digit;
	logic [13:0] acc_base;
	logic [13:0] acc_n;
	logic        err_n;
	logic        in_range;
	logic [13:0] store_v;

	assign slot_free  = !res_valid_q || !result_stall;
	assign is_term    = !start_s1 && (pos_q == dtp_pkg::TERM_POS);
	assign proc       = valid_s1 && (!is_term || slot_free);
	assign char_stall = valid_s1 && !proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!char_stall && char_valid) begin
			char_s1  <= char_code;
			start_s1 <= start_flag;
		end
	end

	// a start character discards any string in progress
	always_comb begin
		pos_e  = start_s1 ? 4'd0 : pos_q;
		acc_e  = start_s1 ? 14'd0 : acc_q;
		wild_e = start_s1 ? 6'd0 : wild_q;
		err_e  = start_s1 ? 1'b0 : err_q;

		fld     = dtp_pkg::field_of(pos_e);
		first_c = dtp_pkg::is_first(pos_e);
		last_c  = dtp_pkg::is_last(pos_e);

		wild_n = wild_e;
		if (first_c && (char_s1 == dtp_pkg::CHAR_WILD)) begin
			wild_n[fld] = 1'b1;
		end
		wild_bit = wild_n[fld];

		is_digit = (char_s1 >= dtp_pkg::CHAR_ZERO) && (char_s1 <= dtp_pkg::CHAR_NINE);
		acc_base = first_c ? 14'd0 : acc_e;
		acc_n    = acc_base;
		err_n    = err_e;
		if (!wild_bit) begin
			if (is_digit) begin
				acc_n = (acc_base << 3) + (acc_base << 1) +
					{10'd0, char_s1[3:0]};
			end else begin
				err_n = 1'b1;
			end
		end

		in_range = (acc_n >= dtp_pkg::field_lo(fld)) && (acc_n <= dtp_pkg::field_hi(fld));
		store_v  = acc_n;
		if (wild_bit) begin
			store_v = 14'd0;
		end else if (!in_range) begin
			store_v = 14'd0;
			if (last_c) begin
				err_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= dtp_pkg::IDLE_POS;
			acc_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			wild_q   <= '0;
			err_q    <= 1'b0;
		end else if (proc) begin
			if (start_s1) begin
				year_q   <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end
			if (pos_e == dtp_pkg::TERM_POS) begin
				pos_q <= dtp_pkg::IDLE_POS;
			end else if (pos_e != dtp_pkg::IDLE_POS) begin
				pos_q  <= pos_e + 4'd1;
				acc_q  <= acc_n;
				wild_q <= wild_n;
				err_q  <= err_n;
				if (last_c) begin
					unique case (fld)
						dtp_pkg::F_YEAR:   year_q   <= store_v;
						dtp_pkg::F_MONTH:  month_q  <= store_v[3:0];
						dtp_pkg::F_DAY:    day_q    <= store_v[4:0];
						dtp_pkg::F_HOUR:   hour_q   <= store_v[4:0];
						dtp_pkg::F_MINUTE: minute_q <= store_v[5:0];
						default:           second_q <= store_v[5:0];
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && is_term) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && is_term) begin
			priority if (char_s1 != dtp_pkg::CHAR_NUL) begin
				status_q     <= dtp_pkg::ST_BAD_TERM;
				year_res_q   <= '0;
				month_res_q  <= '0;
				day_res_q    <= '0;
				hour_res_q   <= '0;
				minute_res_q <= '0;
				second_res_q <= '0;
				wild_res_q   <= '0;
			end else if (err_q) begin
				status_q     <= dtp_pkg::ST_FIELD_ERR;
				year_res_q   <= '0;
				month_res_q  <= '0;
				day_res_q    <= '0;
				hour_res_q   <= '0;
				minute_res_q <= '0;
				second_res_q <= '0;
				wild_res_q   <= wild_q;
			end else begin
				status_q     <= dtp_pkg::ST_OK;
				year_res_q   <= year_q;
				month_res_q  <= month_q;
				day_res_q    <= day_q;
				hour_res_q   <= hour_q;
				minute_res_q <= minute_q;
				second_res_q <= second_q;
				wild_res_q   <= wild_q;
			end
		end
	end

	assign result_valid   = res_valid_q;
	assign status         = status_q;
	assign year           = year_res_q;
	assign month          = month_res_q;
	assign day            = day_res_q;
	assign hour           = hour_res_q;
	assign minute         = minute_res_q;
	assign second         = second_res_q;
	assign wildcard_flags = wild_res_q;

endmodule

>>> sv/dtp_checker.sv
// Port-level checks on the date-time string parser, bound to its top level.
// Depends on dtp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  status,
	input logic [13:0] year,
	input logic [3:0]  month,
	input logic [4:0]  day,
	input logic [4:0]  hour,
	input logic [5:0]  minute,
	input logic [5:0]  second,
	input logic [5:0]  wildcard_flags
);

	logic vals_zero;
	logic res_held;
	logic res_err;
	logic res_bad_term;
	logic res_ok;
	logic dates_ok;
	logic status_known;

	assign vals_zero = (year == 14'd0) && (month == 4'd0) && (day == 5'd0) &&
		(hour == 5'd0) && (minute == 6'd0) && (second == 6'd0);
	assign res_held     = result_valid && result_stall;
	assign res_err      = result_valid && (status != dtp_pkg::ST_OK);
	assign res_bad_term = result_valid && (status == dtp_pkg::ST_BAD_TERM);
	assign res_ok       = result_valid && (status == dtp_pkg::ST_OK);
	// a non-wildcard date field in an ok result is at least one, and a month at most twelve
	assign dates_ok = (wildcard_flags[0] || (year != 14'd0)) &&
		(wildcard_flags[1] || ((month != 4'd0) && (month <= 4'd12))) &&
		(wildcard_flags[2] || (day != 5'd0));
	assign status_known = (status == dtp_pkg::ST_OK) || (status == dtp_pkg::ST_BAD_TERM) ||
		(status == dtp_pkg::ST_FIELD_ERR);

	// hold a stalled result word
	`ASSERT_NEXT(a_res_hold, res_held, result_valid && $stable(status) && $stable(year), "held")

	`ASSERT_IMPL(a_err_zero, res_err, vals_zero, "error result carries values")

	`ASSERT_IMPL(a_term_flags, res_bad_term, wildcard_flags == 6'd0, "bad terminator keeps flags")

	`ASSERT_IMPL(a_ok_range, res_ok, dates_ok, "ok result out of range")

	`ASSERT_IMPL(a_status_code, result_valid, status_known, "undefined status code")

endmodule

bind datetime_string_parser dtp_checker u_dtp_checker (.*);
